// File: rtl/zero_run_escape_encoder_unit_assert.svh
// assertion macros shared by the encoder checker
`ifndef ZERO_RUN_ESCAPE_ENCODER_UNIT_ASSERT_SVH
`define ZERO_RUN_ESCAPE_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ZRLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define ZRLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/zrle_pkg.sv
// shared types and constants for the zero-run escape encoder
`default_nettype none
package zrle_pkg;

	localparam int MAX_LEN_DEF = 1024;
	localparam int BURST_MAX   = 4;

	localparam logic [7:0] ESC_BYTE  = 8'h88;
	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam logic [8:0] RUN_CAP   = 9'd257;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
		logic       not_smaller;
	} out_item_t;

	// all encoded bytes caused by one input item
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      last;
		logic                      ns;
	} burst_t;

endpackage
`default_nettype wire

// File: rtl/zrle_encode.sv
// run state, counters and per-item encoding into a burst of bytes
`default_nettype none
module zrle_encode #(
	parameter int MAX_LEN = zrle_pkg::MAX_LEN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire zrle_pkg::in_item_t item,
	output zrle_pkg::burst_t      burst
);
	import zrle_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] LIMIT = CW'(MAX_LEN);

	logic [8:0]    zero_run_q;
	logic [CW-1:0] bytes_in_q;
	logic [CW-1:0] bytes_out_q;

	logic [8:0]    zr1;
	logic [8:0]    flush_n;
	logic [8:0]    cnt_m2;
	logic [1:0]    fn;
	logic [1:0]    ln;
	logic [7:0]    f0, f1;
	logic [2:0]    cnt_w;
	logic          ns_w;
	logic [8:0]    zr_next;
	logic [CW-1:0] bi_next;
	logic [CW:0]   bo_sum;
	logic [CW-1:0] bo_next;

	// pick the run to flush and the literal bytes
	always_comb begin
		zr1 = zero_run_q + 9'd1;
		if (item.in_byte != ZERO_BYTE) begin
			flush_n = zero_run_q;
			zr_next = 9'd0;
		end else if (zr1 == RUN_CAP || item.in_last) begin
			flush_n = zr1;
			zr_next = 9'd0;
		end else begin
			flush_n = 9'd0;
			zr_next = zr1;
		end
		cnt_m2 = flush_n - 9'd2;
		if (flush_n == 9'd0) begin
			fn = 2'd0;
		end else if (flush_n == 9'd1) begin
			fn = 2'd1;
		end else begin
			fn = 2'd2;
		end
		f0 = (flush_n >= 9'd3) ? ESC_BYTE : ZERO_BYTE;
		f1 = (flush_n >= 9'd3) ? cnt_m2[7:0] : ZERO_BYTE;
		if (item.in_byte == ZERO_BYTE) begin
			ln = 2'd0;
		end else if (item.in_byte == ESC_BYTE) begin
			ln = 2'd2;
		end else begin
			ln = 2'd1;
		end
		cnt_w = {1'b0, fn} + {1'b0, ln};
	end

	// lay out flushed run first, then the literal
	always_comb begin
		burst.bytes = {BURST_MAX{ZERO_BYTE}};
		case (fn)
			2'd0: begin
				burst.bytes[0] = item.in_byte;
			end
			2'd1: begin
				burst.bytes[0] = f0;
				burst.bytes[1] = item.in_byte;
			end
			default: begin
				burst.bytes[0] = f0;
				burst.bytes[1] = f1;
				burst.bytes[2] = item.in_byte;
			end
		endcase
		burst.cnt  = cnt_w;
		burst.last = item.in_last;
		burst.ns   = ns_w;
	end

	// saturating counts and the size verdict
	always_comb begin
		bi_next = (bytes_in_q < LIMIT) ? bytes_in_q + CW'(1) : LIMIT;
		bo_sum  = {1'b0, bytes_out_q} + (CW+1)'(cnt_w);
		bo_next = (bo_sum > {1'b0, LIMIT}) ? LIMIT : bo_sum[CW-1:0];
		ns_w    = bo_next >= bi_next;
	end

	// state update per accepted item, cleared at end of message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q  <= 9'd0;
			bytes_in_q  <= '0;
			bytes_out_q <= '0;
		end else if (take) begin
			if (item.in_last) begin
				zero_run_q  <= 9'd0;
				bytes_in_q  <= '0;
				bytes_out_q <= '0;
			end else begin
				zero_run_q  <= zr_next;
				bytes_in_q  <= bi_next;
				bytes_out_q <= bo_next;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/zrle_out_buf.sv
// result register holding one burst, drained one byte per cycle while take is high
`default_nettype none
module zrle_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic               take,
	input  wire zrle_pkg::burst_t   burst,
	output logic                    valid,
	output logic                    room,
	output zrle_pkg::out_item_t     item
);
	import zrle_pkg::*;

	logic [BURST_MAX-1:0][7:0] bytes_q;
	logic [2:0]                cnt_q;
	logic                      last_q;
	logic                      ns_q;

	assign valid = cnt_q != 3'd0;
	// can load when empty or when the final byte leaves now
	assign room  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && take);

	// front byte and its flags
	always_comb begin
		item.out_byte    = bytes_q[0];
		item.run_last    = cnt_q == 3'd1;
		item.frame_end   = (cnt_q == 3'd1) && last_q;
		item.not_smaller = (cnt_q == 3'd1) && last_q && ns_q;
	end

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// payload: load or shift toward the front
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
			last_q  <= burst.last;
			ns_q    <= burst.ns;
		end else if (take) begin
			bytes_q <= {ZERO_BYTE, bytes_q[BURST_MAX-1:1]};
		end
	end

endmodule
`default_nettype wire

// File: rtl/zero_run_escape_encoder_unit.sv
// Zero-run escape encoder top level.
// The first encoded byte of an item is registered and appears in the cycle after the item is accepted.
// The encoder takes one item per cycle while each item yields at most one byte and the output is
// not stalled; an item that yields more bytes (up to four) stalls the input until its final byte is taken.
// Reset clears the held run, both counts and the result register's fill level; no clearing pass.
`default_nettype none
module zero_run_escape_encoder_unit #(
	parameter int MAX_LEN = zrle_pkg::MAX_LEN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire zrle_pkg::in_item_t  byte_item,
	output logic                     code_valid,
	input  wire logic                code_stall,
	output zrle_pkg::out_item_t      code_item
);
	import zrle_pkg::*;

	burst_t burst;
	logic   room;
	logic   take_in;
	logic   take_out;

	// handshakes
	assign take_out   = code_valid && !code_stall;
	assign byte_stall = !room;
	assign take_in    = byte_valid && room;

	zrle_encode #(
		.MAX_LEN(MAX_LEN)
	) u_encode (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take_in),
		.item  (byte_item),
		.burst (burst)
	);

	zrle_out_buf u_out_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (take_in),
		.take  (take_out),
		.burst (burst),
		.valid (code_valid),
		.room  (room),
		.item  (code_item)
	);

endmodule
`default_nettype wire

// File: rtl/zrle_checker.sv
// port-level checks for the encoder and their binding
`default_nettype none
`include "zero_run_escape_encoder_unit_assert.svh"
module zrle_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                byte_stall,
	input wire logic                code_valid,
	input wire logic                code_stall,
	input wire zrle_pkg::out_item_t code_item
);
	import zrle_pkg::*;

	// a held result stays offered
	`ZRLE_ASSERT_NEXT(a_hold_valid, code_valid && code_stall, code_valid, "result item dropped")
	// a held result does not change
	`ZRLE_ASSERT_NEXT(a_hold_data, code_valid && code_stall, $stable(code_item), "result item changed")
	// end of message closes the burst of its item
	`ZRLE_ASSERT_NOW(a_end_run, code_valid && code_item.frame_end, code_item.run_last,
		"frame_end without run_last")
	// size verdict only with end of message
	`ZRLE_ASSERT_NOW(a_ns_end, code_valid && code_item.not_smaller, code_item.frame_end,
		"not_smaller without frame_end")
	// no new item while a burst still has more than its final byte
	`ZRLE_ASSERT_NOW(a_busy_stall, code_valid && !code_item.run_last, byte_stall,
		"input taken mid-burst")

endmodule

bind zero_run_escape_encoder_unit zrle_checker u_chk (.*);
`default_nettype wire
